[src/sortable_array_with_quicksort_macros.svh]
// Assertion helpers shared by the block's modules.
`ifndef SORTABLE_ARRAY_WITH_QUICKSORT_MACROS_SVH
`define SORTABLE_ARRAY_WITH_QUICKSORT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define SAP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequence checked in the cycle after the antecedent.
`define SAP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sap_pkg.sv]
`timescale 1ns / 1ps
package sap_pkg;

   localparam int DEPTH_DEF   = 256;
   localparam int STACK_SLOTS = 18;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_SORT   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic le;
      logic eq;
   } cmp_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stk_stat_type;

endpackage

[src/sap_ram.sv]
`timescale 1ns / 1ps
module sap_ram import sap_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                we,
   input  logic [AW-1:0]       waddr,
   input  logic signed [31:0]  wdata,
   input  logic [AW-1:0]       raddr,
   output logic signed [31:0]  rdata
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/sap_cmp.sv]
`timescale 1ns / 1ps
module sap_cmp import sap_pkg::*; (
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output cmp_type            res
);

   always_comb begin
      res.le = (a <= b);
      res.eq = (a == b);
   end

endmodule

[src/sap_stack.sv]
`timescale 1ns / 1ps
module sap_stack import sap_pkg::*; #(
   parameter int SLOTS = STACK_SLOTS,
   parameter int W     = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic          pop,
   input  logic [W-1:0]  push_lo,
   input  logic [W-1:0]  push_hi,
   output logic [W-1:0]  top_lo,
   output logic [W-1:0]  top_hi,
   output stk_stat_type  stat
);

   localparam int SPW = $clog2(SLOTS + 1);
   localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [W-1:0]   lo_ff [SLOTS];
   logic [W-1:0]   hi_ff [SLOTS];
   logic [SPW-1:0] sp_ff, sp_in;
   logic [SPW-1:0] top_idx;

   assign top_idx    = sp_ff - SPW'(1);
   assign top_lo     = lo_ff[top_idx[AW-1:0]];
   assign top_hi     = hi_ff[top_idx[AW-1:0]];
   assign stat.empty = (sp_ff == '0);
   assign stat.full  = (sp_ff == SPW'(SLOTS));

   always_comb begin
      sp_in = sp_ff;
      if (push) begin
         sp_in = sp_ff + SPW'(1);
      end else if (pop) begin
         sp_in = top_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
      if (push) begin
         lo_ff[sp_ff[AW-1:0]] <= push_lo;
         hi_ff[sp_ff[AW-1:0]] <= push_hi;
      end
   end

   `include "sortable_array_with_quicksort_macros.svh"

   `SAP_ASSERT_IMP(a_no_push_full, push, !stat.full, "push into full range stack")
   `SAP_ASSERT_IMP(a_no_pop_empty, pop, !stat.empty, "pop from empty range stack")
   `SAP_ASSERT_IMP(a_push_pop_excl, push, !pop, "push and pop in one cycle")

endmodule

[src/sortable_array_with_quicksort.sv]
`timescale 1ns / 1ps
// Sortable array: a store of up to DEPTH signed 32-bit entries plus a count.
// Input channel req_*: one item carries a command (append, delete, read,
// sort range) with its operand and range indices; it is taken when req_valid
// is high and req_stall low. req_stall is high whenever a command is in work.
// Result channel rsp_*: one item per command, read_value, ok and the entry
// count after the command, held in an output register until rsp_stall is low.
// Append, a read out of range and a refused or empty sort go straight to the
// done state; a good read first waits for the registered store read. Delete
// scans entry by entry up to the match, then shifts each remaining entry down
// with a read and a write. Sort is Lomuto quicksort on one read port, one
// write port and one shared comparator: each element examined is read and
// compared with the pivot, each swap adds a read and two writes, and each
// partition also reads the pivot and writes it into its final place.
// A command whose result finds the output register full waits until the
// receiver takes the previous item; the block returns to idle as the result
// moves into the output register, after which it can take the next item.
// Reset clears the count, the range stack and both channels; stored entries
// are left as they are and are only read below the count.
module sortable_array_with_quicksort import sap_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_operand,
   input  logic [7:0]         req_start_index,
   input  logic [7:0]         req_end_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_ok,
   output logic [8:0]         rsp_entry_count
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int PW    = IDX_W + 1;

   typedef enum logic [15:0] {
      ST_IDLE  = 16'h0001,
      ST_RDW   = 16'h0002,
      ST_DRD   = 16'h0004,
      ST_DCK   = 16'h0008,
      ST_DSH   = 16'h0010,
      ST_DSW   = 16'h0020,
      ST_SLOOP = 16'h0040,
      ST_SPIV  = 16'h0080,
      ST_SRJ   = 16'h0100,
      ST_SVJ   = 16'h0200,
      ST_SVD   = 16'h0400,
      ST_SWJ   = 16'h0800,
      ST_SFD   = 16'h1000,
      ST_SFH   = 16'h2000,
      ST_SSPL  = 16'h4000,
      ST_DONE  = 16'h8000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   i_ff, i_in;
   logic [PW-1:0]      lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in, dst_ff, dst_in;
   logic signed [31:0] op_ff, op_in, pivot_ff, pivot_in, vj_ff, vj_in, vd_ff, vd_in;
   logic signed [31:0] res_val_ff, res_val_in;
   logic               res_ok_ff, res_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_val_ff, rsp_val_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [8:0]         rsp_cnt_ff, rsp_cnt_in;

   logic               we;
   logic [IDX_W-1:0]   waddr, raddr;
   logic signed [31:0] wdata, rdata, cmp_b;
   cmp_type            cmp;
   logic               stk_push, stk_pop;
   logic [PW-1:0]      stk_push_lo, stk_push_hi, stk_top_lo, stk_top_hi;
   stk_stat_type       stk_st;
   logic [PW-1:0]      left_len, right_len;
   logic               accept, rsp_free;
   cmd_type            cmd;

   sap_ram #(.DEPTH(DEPTH), .AW(IDX_W)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   sap_cmp u_cmp (.a(rdata), .b(cmp_b), .res(cmp));

   sap_stack #(.SLOTS(STACK_SLOTS), .W(PW)) u_stack (
      .clock(clock), .reset(reset), .push(stk_push), .pop(stk_pop),
      .push_lo(stk_push_lo), .push_hi(stk_push_hi),
      .top_lo(stk_top_lo), .top_hi(stk_top_hi), .stat(stk_st)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign accept          = req_valid && !req_stall;
   assign cmd             = cmd_type'(req_command);
   assign rsp_free        = !rsp_valid_ff || !rsp_stall;
   assign cmp_b           = (state_ff == ST_SVJ) ? pivot_ff : op_ff;
   assign left_len        = dst_ff - lo_ff;
   assign right_len       = hi_ff - dst_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_val_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_entry_count = rsp_cnt_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      i_in        = i_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      j_in        = j_ff;
      dst_in      = dst_ff;
      op_in       = op_ff;
      pivot_in    = pivot_ff;
      vj_in       = vj_ff;
      vd_in       = vd_ff;
      res_val_in  = res_val_ff;
      res_ok_in   = res_ok_ff;
      we          = 1'b0;
      waddr       = IDX_W'(dst_ff);
      wdata       = vj_ff;
      raddr       = IDX_W'(j_ff);
      stk_push    = 1'b0;
      stk_pop     = 1'b0;
      stk_push_lo = lo_ff;
      stk_push_hi = dst_ff - PW'(1);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_operand;
               res_val_in = '0;
               res_ok_in  = 1'b0;
               i_in       = '0;
               case (cmd)
                  CMD_APPEND: begin
                     waddr = IDX_W'(count_ff);
                     wdata = req_operand;
                     if (count_ff < CNT_W'(DEPTH)) begin
                        we        = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                        res_ok_in = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  CMD_DELETE: state_in = ST_DRD;
                  CMD_READ: begin
                     raddr = IDX_W'($unsigned(req_operand));
                     if (!req_operand[31] && $unsigned(req_operand) < 32'(count_ff)) begin
                        state_in = ST_RDW;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     lo_in = PW'(req_start_index);
                     hi_in = PW'(req_end_index);
                     if (32'(req_end_index) < 32'(count_ff)) begin
                        res_ok_in = 1'b1;
                        state_in  = (req_start_index < req_end_index) ? ST_SLOOP : ST_DONE;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_RDW: begin
            res_val_in = rdata;
            res_ok_in  = 1'b1;
            state_in   = ST_DONE;
         end
         // delete: find the first match, then shift the tail down by one
         ST_DRD: begin
            raddr = IDX_W'(i_ff);
            state_in = (i_ff == count_ff) ? ST_DONE : ST_DCK;
         end
         ST_DCK: begin
            if (cmp.eq) begin
               state_in = ST_DSH;
            end else begin
               i_in     = i_ff + CNT_W'(1);
               state_in = ST_DRD;
            end
         end
         ST_DSH: begin
            raddr = IDX_W'(i_ff + CNT_W'(1));
            if (i_ff + CNT_W'(1) < count_ff) begin
               state_in = ST_DSW;
            end else begin
               count_in  = count_ff - CNT_W'(1);
               res_ok_in = 1'b1;
               state_in  = ST_DONE;
            end
         end
         ST_DSW: begin
            we       = 1'b1;
            waddr    = IDX_W'(i_ff);
            wdata    = rdata;
            i_in     = i_ff + CNT_W'(1);
            state_in = ST_DSH;
         end
         // sort: take the next range, or pop one, or finish
         ST_SLOOP: begin
            raddr = IDX_W'(hi_ff);
            if (lo_ff < hi_ff) begin
               state_in = ST_SPIV;
            end else if (stk_st.empty) begin
               state_in = ST_DONE;
            end else begin
               stk_pop = 1'b1;
               lo_in   = stk_top_lo;
               hi_in   = stk_top_hi;
            end
         end
         ST_SPIV: begin
            pivot_in = rdata;
            j_in     = lo_ff;
            dst_in   = lo_ff;
            state_in = ST_SRJ;
         end
         ST_SRJ: begin
            if (j_ff == hi_ff) begin
               raddr    = IDX_W'(dst_ff);
               state_in = ST_SFD;
            end else begin
               state_in = ST_SVJ;
            end
         end
         ST_SVJ: begin
            vj_in = rdata;
            raddr = IDX_W'(dst_ff);
            if (cmp.le) begin
               state_in = ST_SVD;
            end else begin
               j_in     = j_ff + PW'(1);
               state_in = ST_SRJ;
            end
         end
         ST_SVD: begin
            vd_in    = rdata;
            we       = 1'b1;
            state_in = ST_SWJ;
         end
         ST_SWJ: begin
            we       = 1'b1;
            waddr    = IDX_W'(j_ff);
            wdata    = vd_ff;
            dst_in   = dst_ff + PW'(1);
            j_in     = j_ff + PW'(1);
            state_in = ST_SRJ;
         end
         ST_SFD: begin
            vd_in    = rdata;
            we       = 1'b1;
            wdata    = pivot_ff;
            state_in = ST_SFH;
         end
         ST_SFH: begin
            we       = 1'b1;
            waddr    = IDX_W'(hi_ff);
            wdata    = vd_ff;
            state_in = ST_SSPL;
         end
         // keep the smaller side, stack the larger one
         ST_SSPL: begin
            if (left_len >= right_len) begin
               stk_push = (left_len >= PW'(2)) && !stk_st.full;
               lo_in    = dst_ff + PW'(1);
            end else begin
               stk_push    = (right_len >= PW'(2)) && !stk_st.full;
               stk_push_lo = dst_ff + PW'(1);
               stk_push_hi = hi_ff;
               hi_in       = (dst_ff == '0) ? '0 : dst_ff - PW'(1);
            end
            state_in = ST_SLOOP;
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_val_in   = rsp_val_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_val_in   = res_val_ff;
         rsp_ok_in    = res_ok_ff;
         rsp_cnt_in   = 9'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff       <= i_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      j_ff       <= j_in;
      dst_ff     <= dst_in;
      op_ff      <= op_in;
      pivot_ff   <= pivot_in;
      vj_ff      <= vj_in;
      vd_ff      <= vd_in;
      res_val_ff <= res_val_in;
      res_ok_ff  <= res_ok_in;
      rsp_val_ff <= rsp_val_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   `include "sortable_array_with_quicksort_macros.svh"

   `SAP_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `SAP_ASSERT_NEXT(a_done_loads, state_ff == ST_DONE && rsp_free, rsp_valid_ff,
                    "finished item not presented")
   `SAP_ASSERT_IMP(a_sort_range, state_ff == ST_SRJ, j_ff <= hi_ff && dst_ff <= j_ff,
                   "partition indices out of order")

endmodule
